### rtl/core/scea_pkg.sv
// package for the sprite cluster edge anchor: types, constants, register codes
// used by scea_front, scea_back and sprite_cluster_edge_anchor
package scea_pkg;

  localparam int MaxSprites = 64;
  localparam int IdxW       = $clog2(MaxSprites);
  localparam int CntW       = IdxW + 1;

  // register indexes
  localparam logic [1:0] REG_BASE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_WIDE_WIDTH    = 2'd1;
  localparam logic [1:0] REG_CENTRE_OFFSET = 2'd2;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
  } sprite_t;

  // one closed frame handed from front to back
  typedef struct packed {
    logic [CntW-1:0] count;
  } frame_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_PAIR_RD, ST_PAIR_CMP, ST_FIND_A, ST_FIND_B,
    ST_EXT_INIT, ST_EXT_FIND, ST_EXT_UPD, ST_OUT_FIND, ST_OUT_CALC, ST_OUT_EMIT
  } back_state_t;

endpackage

### rtl/core/scea_front.sv
// front part: accepts sprite items, writes them into the frame store
// depends on scea_pkg
module scea_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  scea_pkg::sprite_t      in_sprite,
  input  logic                   in_frame_end,
  input  logic                   frame_busy,
  output logic                   wr_en,
  output logic [scea_pkg::IdxW-1:0] wr_idx,
  output scea_pkg::sprite_t      wr_data,
  output logic                   frame_valid,
  output scea_pkg::frame_t       frame
);
  import scea_pkg::*;

  logic [CntW-1:0] count_r, count_nxt;
  logic            fv_r, fv_nxt;
  logic [CntW-1:0] fc_r, fc_nxt;
  logic            acc;
  logic [CntW-1:0] count_inc;

  // front stalls while a closed frame waits or is being processed
  assign full    = fv_r || frame_busy;
  assign acc     = push && !full;
  assign wr_en   = acc;
  assign wr_idx  = count_r[IdxW-1:0];
  assign wr_data = in_sprite;
  assign count_inc = count_r + CntW'(1);

  // frame closing on end marker or full queue
  always_comb begin
    count_nxt = count_r;
    fv_nxt    = fv_r;
    fc_nxt    = fc_r;
    if (acc) begin
      if (in_frame_end || count_inc == CntW'(MaxSprites)) begin
        count_nxt = '0;
        fv_nxt    = 1'b1;
        fc_nxt    = count_inc;
      end else begin
        count_nxt = count_inc;
      end
    end else if (fv_r && frame_busy) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fv_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      fv_r    <= fv_nxt;
    end
    fc_r <= fc_nxt;
  end

  assign frame_valid = fv_r;
  assign frame.count = fc_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CntW'(MaxSprites)) else $error("fill count out of range");
  a_no_write_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en) else $error("store write while stalled");
  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r |-> (fc_r != '0)) else $error("empty frame handed on");
`endif

endmodule

### rtl/core/scea_back.sv
// back part: store, union-find grouping, extents and result register
// depends on scea_pkg
module scea_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [scea_pkg::IdxW-1:0] wr_idx,
  input  scea_pkg::sprite_t      wr_data,
  input  logic                   frame_valid,
  input  scea_pkg::frame_t       frame,
  output logic                   frame_busy,
  input  logic [11:0]            base_width,
  input  logic [11:0]            wide_width,
  input  logic [10:0]            centre_offset,
  input  logic [11:0]            screen_height,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [15:0]     out_moved_x,
  output logic                   out_needs_clip,
  output logic                   out_last_out
);
  import scea_pkg::*;

  // memories
  sprite_t          store_m [MaxSprites];
  logic [IdxW-1:0]  link_m  [MaxSprites];
  logic signed [16:0] left_m  [MaxSprites];
  logic signed [16:0] right_m [MaxSprites];

  back_state_t state_r, state_nxt;
  logic [CntW-1:0] n_r, n_nxt;
  logic [IdxW-1:0] i_r, i_nxt, j_r, j_nxt, p_r, p_nxt, ra_r, ra_nxt;
  logic [IdxW-1:0] lk_r;
  sprite_t a_r, a_nxt, b_r, b_nxt;
  logic signed [16:0] gl_r, gl_nxt, gr_r, gr_nxt;

  // derived measures, held while a frame runs
  logic [11:0] gap_r, narrow_r, far_r, centre_r;
  logic [11:0] base80;
  logic [12:0] b6;
  logic [14:0] b12;

  // output register
  logic            ov_r, ov_nxt;
  logic signed [15:0] ox_r, ox_nxt;
  logic            oc_r, oc_nxt, ol_r, ol_nxt;

  // write ports
  logic            lw_en;
  logic [IdxW-1:0] lw_idx, lw_val;
  logic            ew_en;
  logic [IdxW-1:0] ew_idx;
  logic signed [16:0] ew_l, ew_r;

  // base/80, base*6/10 and base*12/100 by reciprocal multiplication
  logic [25:0] recip;
  assign recip  = 26'(base_width) * 26'd13108;
  assign base80 = 12'(recip >> 20);
  assign b6     = 13'((32'(base_width) * 32'd39322) >> 16);
  assign b12    = 15'((32'(base_width) * 32'd31458) >> 18);

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      gap_r    <= (base80 < 12'd2) ? 12'd2 : base80;
      narrow_r <= 12'(b6);
      far_r    <= 12'(b12);
      centre_r <= {1'b0, base_width[11:1]};
    end
  end

  // memory writes and reads
  always_ff @(posedge clk) begin
    if (wr_en) store_m[wr_idx] <= wr_data;
    if (lw_en) link_m[lw_idx] <= lw_val;
    if (ew_en) begin
      left_m[ew_idx]  <= ew_l;
      right_m[ew_idx] <= ew_r;
    end
    lk_r <= link_m[p_nxt];
  end

  // pair test
  logic signed [17:0] ay1, by1, top, bot, ovl;
  logic [11:0] minh;
  logic near;
  always_comb begin
    ay1  = 18'(a_r.y) + 18'(signed'({1'b0, a_r.h}));
    by1  = 18'(b_r.y) + 18'(signed'({1'b0, b_r.h}));
    top  = (a_r.y > b_r.y) ? 18'(a_r.y) : 18'(b_r.y);
    bot  = (ay1 < by1) ? ay1 : by1;
    ovl  = bot - top;
    minh = (a_r.h < b_r.h) ? a_r.h : b_r.h;
    near = (18'(a_r.x) - 18'(signed'({1'b0, gap_r})) <
            18'(b_r.x) + 18'(signed'({1'b0, b_r.w}))) &&
           (18'(b_r.x) - 18'(signed'({1'b0, gap_r})) <
            18'(a_r.x) + 18'(signed'({1'b0, a_r.w}))) &&
           (signed'({ovl, 1'b0}) >= 19'(signed'({1'b0, minh}))) && (minh != '0);
  end

  // output arithmetic
  logic signed [17:0] cw, csum, cc, d;
  logic signed [12:0] cen_s;
  logic [11:0] shift;
  logic signed [15:0] nx;
  logic signed [17:0] nxw, yh;
  logic clip;
  logic signed [16:0] x1;
  always_comb begin
    cw    = 18'(gr_r) - 18'(gl_r);
    csum  = 18'(gl_r) + 18'(gr_r);
    cc    = (csum + ((csum < 0) ? 18'sd1 : 18'sd0)) >>> 1;
    cen_s = 13'(signed'({1'b0, centre_r}));
    d     = cc - 18'(cen_s);
    if (d < 0) d = -d;
    shift = {1'b0, centre_offset};
    if (cw < 18'(signed'({1'b0, narrow_r})) && d > 18'(signed'({1'b0, far_r})))
      shift = (cc < 18'(cen_s)) ? 12'd0 : {centre_offset, 1'b0};
    nx   = a_r.x + 16'(shift);
    nxw  = 18'(nx) + 18'(signed'({1'b0, a_r.w}));
    yh   = 18'(a_r.y) + 18'(signed'({1'b0, a_r.h}));
    clip = nx < 0 || a_r.y < 0 || nxw >= 18'(signed'({1'b0, wide_width})) ||
           yh >= 18'(signed'({1'b0, screen_height}));
    x1   = 17'(a_r.x) + 17'(signed'({1'b0, a_r.w}));
  end

  logic [IdxW-1:0] last_idx;
  assign last_idx = IdxW'(n_r - CntW'(1));

  // sequencer; root searches follow one registered link per cycle
  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; i_nxt = i_r; j_nxt = j_r; p_nxt = p_r; ra_nxt = ra_r;
    a_nxt = a_r; b_nxt = b_r; gl_nxt = gl_r; gr_nxt = gr_r;
    ov_nxt = ov_r; ox_nxt = ox_r; oc_nxt = oc_r; ol_nxt = ol_r;
    lw_en = 1'b0; lw_idx = i_r; lw_val = i_r;
    ew_en = 1'b0; ew_idx = i_r; ew_l = 17'sh0FFFF; ew_r = -17'sh10000;
    if (ov_r && pop) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: if (frame_valid) begin
        n_nxt = frame.count; i_nxt = '0; state_nxt = ST_INIT;
      end
      ST_INIT: begin
        lw_en = 1'b1;
        if (i_r == last_idx) begin
          i_nxt = '0; j_nxt = IdxW'(1);
          state_nxt = (n_r == CntW'(1)) ? ST_EXT_INIT : ST_PAIR_RD;
        end else i_nxt = i_r + IdxW'(1);
      end
      ST_PAIR_RD: begin
        a_nxt = store_m[i_r]; b_nxt = store_m[j_r]; state_nxt = ST_PAIR_CMP;
      end
      ST_PAIR_CMP: begin
        if (near) begin p_nxt = i_r; state_nxt = ST_FIND_A; end
        else if (j_r == last_idx) begin
          if (i_r + IdxW'(1) == last_idx) begin
            i_nxt = '0; state_nxt = ST_EXT_INIT;
          end else begin
            i_nxt = i_r + IdxW'(1); j_nxt = i_r + IdxW'(2); state_nxt = ST_PAIR_RD;
          end
        end else begin j_nxt = j_r + IdxW'(1); state_nxt = ST_PAIR_RD; end
      end
      ST_FIND_A: begin
        if (lk_r == p_r) begin ra_nxt = p_r; p_nxt = j_r; state_nxt = ST_FIND_B; end
        else p_nxt = lk_r;
      end
      ST_FIND_B: begin
        if (lk_r == p_r) begin
          if (p_r != ra_r) begin lw_en = 1'b1; lw_idx = p_r; lw_val = ra_r; end
          if (j_r == last_idx) begin
            if (i_r + IdxW'(1) == last_idx) begin
              i_nxt = '0; state_nxt = ST_EXT_INIT;
            end else begin
              i_nxt = i_r + IdxW'(1); j_nxt = i_r + IdxW'(2); state_nxt = ST_PAIR_RD;
            end
          end else begin j_nxt = j_r + IdxW'(1); state_nxt = ST_PAIR_RD; end
        end else p_nxt = lk_r;
      end
      ST_EXT_INIT: begin
        ew_en = 1'b1;
        if (i_r == last_idx) begin i_nxt = '0; state_nxt = ST_EXT_FIND; p_nxt = '0; end
        else i_nxt = i_r + IdxW'(1);
        if (i_r == last_idx) a_nxt = store_m['0];
      end
      ST_EXT_FIND: begin
        if (lk_r == p_r) begin
          ra_nxt = p_r; gl_nxt = left_m[p_r]; gr_nxt = right_m[p_r];
          state_nxt = ST_EXT_UPD;
        end else p_nxt = lk_r;
      end
      ST_EXT_UPD: begin
        ew_en = 1'b1; ew_idx = ra_r;
        ew_l = (17'(a_r.x) < gl_r) ? 17'(a_r.x) : gl_r;
        ew_r = (x1 > gr_r) ? x1 : gr_r;
        if (i_r == last_idx) begin i_nxt = '0; p_nxt = '0; state_nxt = ST_OUT_FIND; end
        else begin i_nxt = i_r + IdxW'(1); p_nxt = i_r + IdxW'(1); state_nxt = ST_EXT_FIND; end
        a_nxt = store_m[i_r + IdxW'(1)];
        if (i_r == last_idx) a_nxt = store_m['0];
      end
      ST_OUT_FIND: begin
        if (lk_r == p_r) begin
          gl_nxt = left_m[p_r]; gr_nxt = right_m[p_r]; state_nxt = ST_OUT_CALC;
        end else p_nxt = lk_r;
      end
      ST_OUT_CALC: if (!ov_nxt) begin
        ov_nxt = 1'b1; ox_nxt = nx; oc_nxt = clip; ol_nxt = (i_r == last_idx);
        state_nxt = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        if (i_r == last_idx) state_nxt = ST_IDLE;
        else begin
          i_nxt = i_r + IdxW'(1); p_nxt = i_r + IdxW'(1);
          a_nxt = store_m[i_r + IdxW'(1)]; state_nxt = ST_OUT_FIND;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    n_r <= n_nxt; i_r <= i_nxt; j_r <= j_nxt; p_r <= p_nxt; ra_r <= ra_nxt;
    a_r <= a_nxt; b_r <= b_nxt; gl_r <= gl_nxt; gr_r <= gr_nxt;
    ox_r <= ox_nxt; oc_r <= oc_nxt; ol_r <= ol_nxt;
  end

  assign frame_busy     = (state_r != ST_IDLE);
  assign empty          = !ov_r;
  assign out_moved_x    = ox_r;
  assign out_needs_clip = oc_r;
  assign out_last_out   = ol_r;

`ifndef SYNTHESIS
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAIR_CMP) |-> (j_r > i_r)) else $error("pair order broken");
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT_EMIT) |-> ov_r) else $error("emit without result");
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !pop) |=> ov_r) else $error("result dropped");
`endif

endmodule

### rtl/core/sprite_cluster_edge_anchor.sv
// order: a frame closes on its last item; the first result follows after link
// set-up, the pair tests, a root search for each near pair, the extent passes
// and the root search of the first item
// throughput: one frame at a time; items are taken one per cycle while no
// closed frame waits or is being processed; each result is held until it is popped
// reset: synchronous active-low rst_n clears control state and loads the configuration defaults
module sprite_cluster_edge_anchor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_sprite_x,
  input  logic signed [15:0] in_sprite_y,
  input  logic [11:0]        in_sprite_width,
  input  logic [11:0]        in_sprite_height,
  input  logic               in_frame_end,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_moved_x,
  output logic               out_needs_clip,
  output logic               out_last_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import scea_pkg::*;

  logic [11:0] base_r, wide_r, sh_r;
  logic [10:0] co_r;
  sprite_t     in_sprite;
  logic        wr_en, frame_valid, frame_busy;
  logic [IdxW-1:0] wr_idx;
  sprite_t     wr_data;
  frame_t      frame;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 12'd640; wide_r <= 12'd854; co_r <= 11'd107; sh_r <= 12'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_WIDTH:    base_r <= cfg_data;
        REG_WIDE_WIDTH:    wide_r <= cfg_data;
        REG_CENTRE_OFFSET: co_r   <= cfg_data[10:0];
        REG_SCREEN_HEIGHT: sh_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_sprite = '{x: in_sprite_x, y: in_sprite_y,
                       w: in_sprite_width, h: in_sprite_height};

  scea_front u_front (
    .clk, .rst_n, .push, .full, .in_sprite, .in_frame_end, .frame_busy,
    .wr_en, .wr_idx, .wr_data, .frame_valid, .frame
  );

  scea_back u_back (
    .clk, .rst_n, .wr_en, .wr_idx, .wr_data, .frame_valid, .frame, .frame_busy,
    .base_width(base_r), .wide_width(wide_r), .centre_offset(co_r),
    .screen_height(sh_r), .empty, .pop, .out_moved_x, .out_needs_clip,
    .out_last_out
  );

endmodule

### bench/tb_sprite_cluster_edge_anchor.sv
// testbench for sprite_cluster_edge_anchor: random and directed sprite frames,
// a grouping predictor in a scoreboard class; depends on scea_pkg and the rtl
module tb_sprite_cluster_edge_anchor;
  import scea_pkg::*;

  // grouping predictor and store of expected per-sprite placements
  class anchor_scoreboard;
    int unsigned base_w = 640, wide_w = 854, ctr_off = 107, scr_h = 480;
    int fx[MaxSprites], fy[MaxSprites], fw[MaxSprites], fh[MaxSprites];
    int link[MaxSprites], gl[MaxSprites], gr[MaxSprites];
    int fill;
    logic [17:0] placements[$];
    int errors;

    function void report(string what);
      $display("mismatch: %s", what);
      errors++;
    endfunction

    function int root(int i);
      while (link[i] != i) begin
        link[i] = link[link[i]];
        i = link[i];
      end
      return i;
    endfunction

    function void note_sprite(logic signed [15:0] x, logic signed [15:0] y,
                              logic [11:0] w, logic [11:0] h, logic fe);
      int n, gap, base, centre, top, bot, minh, ra, rb, r, cw, cc, d, shift;
      logic signed [15:0] nx;
      logic clip;
      fx[fill] = x; fy[fill] = y; fw[fill] = w; fh[fill] = h;
      fill++;
      if (!fe && fill < MaxSprites) return;
      n = fill;
      fill = 0;
      base = base_w;
      gap = base / 80;
      if (gap < 2) gap = 2;
      for (int i = 0; i < n; i++) link[i] = i;
      // pairwise nearness and union
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++) begin
          top = fy[i] > fy[j] ? fy[i] : fy[j];
          bot = (fy[i] + fh[i]) < (fy[j] + fh[j]) ? fy[i] + fh[i] : fy[j] + fh[j];
          minh = fh[i] < fh[j] ? fh[i] : fh[j];
          if (fx[i] - gap < fx[j] + fw[j] && fx[j] - gap < fx[i] + fw[i] &&
              (bot - top) * 2 >= minh && minh > 0) begin
            ra = root(i);
            rb = root(j);
            if (ra != rb) link[rb] = ra;
          end
        end
      // group x extents
      for (int i = 0; i < n; i++) begin
        gl[i] = 32'sh7fffffff;
        gr[i] = 32'sh80000000;
      end
      for (int i = 0; i < n; i++) begin
        r = root(i);
        if (fx[i] < gl[r]) gl[r] = fx[i];
        if (fx[i] + fw[i] > gr[r]) gr[r] = fx[i] + fw[i];
      end
      // shift per group and clip test
      centre = base / 2;
      for (int i = 0; i < n; i++) begin
        r = root(i);
        cw = gr[r] - gl[r];
        cc = (gl[r] + gr[r]) / 2;
        d = cc - centre;
        if (d < 0) d = -d;
        shift = ctr_off;
        if (cw < base * 6 / 10 && d > base * 12 / 100)
          shift = cc < centre ? 0 : ctr_off * 2;
        nx = 16'(fx[i] + shift);
        clip = nx < 0 || fy[i] < 0 || int'(nx) + fw[i] >= int'(wide_w) ||
               fy[i] + fh[i] >= int'(scr_h);
        placements.push_back({nx, clip, i == n - 1});
      end
    endfunction

    function void check_result(logic signed [15:0] x, logic clip, logic last);
      logic [17:0] e;
      if (placements.size() == 0) begin
        report($sformatf("unexpected result x=%0d", x));
        return;
      end
      e = placements.pop_front();
      if (x !== e[17:2]) report($sformatf("moved_x %0d, want %0d", x, $signed(e[17:2])));
      if (clip !== e[1]) report($sformatf("needs_clip %b, want %b", clip, e[1]));
      if (last !== e[0]) report($sformatf("last_out %b, want %b", last, e[0]));
    endfunction
  endclass

  logic clk = 0, rst_n = 0, push = 0, pop = 0, cfg_we = 0;
  logic full, empty, in_frame_end = 0, out_needs_clip, out_last_out;
  logic signed [15:0] in_sprite_x = 0, in_sprite_y = 0, out_moved_x;
  logic [11:0] in_sprite_width = 0, in_sprite_height = 0, cfg_data = 0;
  logic [1:0] cfg_index = REG_BASE_WIDTH;
  int send_idle_pct, recv_stall_pct;
  anchor_scoreboard sb = new();

  sprite_cluster_edge_anchor uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver stalls
  always @(negedge clk) pop <= ($urandom_range(99) >= recv_stall_pct);

  // accepted items on both sides
  always @(posedge clk) if (rst_n) begin
    if (push && !full)
      sb.note_sprite(in_sprite_x, in_sprite_y, in_sprite_width, in_sprite_height,
                     in_frame_end);
    if (pop && !empty) sb.check_result(out_moved_x, out_needs_clip, out_last_out);
  end

  task send_sprite(int x, int y, int w, int h, bit fe);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk) push = 0;
      repeat ($urandom_range(5)) @(negedge clk);
    end else @(negedge clk);
    push = 1;
    in_sprite_x = 16'(x);
    in_sprite_y = 16'(y);
    in_sprite_width = 12'(w);
    in_sprite_height = 12'(h);
    in_frame_end = fe;
    do @(posedge clk); while (full);
  endtask

  task drain;
    @(negedge clk) push = 0;
    while (sb.placements.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, int unsigned v);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = 12'(v);
    case (idx)
      REG_BASE_WIDTH:    sb.base_w = v & 12'hfff;
      REG_WIDE_WIDTH:    sb.wide_w = v & 12'hfff;
      REG_CENTRE_OFFSET: sb.ctr_off = v & 11'h7ff;
      default:           sb.scr_h = v & 12'hfff;
    endcase
    @(negedge clk) cfg_we = 0;
  endtask

  task write_all(int unsigned b, int unsigned w, int unsigned c, int unsigned s);
    write_reg(REG_BASE_WIDTH, b);
    write_reg(REG_WIDE_WIDTH, w);
    write_reg(REG_CENTRE_OFFSET, c);
    write_reg(REG_SCREEN_HEIGHT, s);
  endtask

  // one frame of n sprites, mostly clustered, some with fully random fields
  task random_frame(int n);
    int ax, ay;
    ax = $urandom_range(700);
    ay = $urandom_range(500);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_sprite($urandom, $urandom, $urandom, $urandom,
                    i == n - 1 && !(n == MaxSprites && $urandom_range(1)));
      else begin
        if ($urandom_range(3) == 0) begin
          ax = $urandom_range(700);
          ay = $urandom_range(500);
        end
        send_sprite(ax + $urandom_range(40) - 10, ay + $urandom_range(20) - 5,
                    $urandom_range(60), $urandom_range(40),
                    i == n - 1 && !(n == MaxSprites && $urandom_range(1)));
        ax += $urandom_range(30);
      end
    end
  endtask

  task random_phase(int items, bit hold_off);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(29) == 0) ? MaxSprites : $urandom_range(1, 8);
      random_frame(n);
      sent += n;
      if (hold_off && sent > items / 2) begin
        drain();
        hold_off = 0;
      end
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // directed: field extremes, near pairs, zero heights, edge groups
    send_sprite(-32768, -32768, 4095, 4095, 1);
    send_sprite(32767, 32767, 0, 0, 1);
    send_sprite(-1, 0, 1, 1, 0);
    send_sprite(32767, 100, 4095, 4095, 1);
    send_sprite(100, 100, 20, 20, 0);
    send_sprite(127, 105, 20, 20, 0);
    send_sprite(148, 112, 20, 20, 0);
    send_sprite(300, 100, 20, 0, 0);
    send_sprite(305, 100, 20, 0, 1);
    send_sprite(10, 200, 30, 10, 0);
    send_sprite(600, 200, 30, 10, 0);
    send_sprite(300, 200, 40, 10, 0);
    send_sprite(0, 460, 30, 20, 0);
    send_sprite(800, 300, 60, 20, 0);
    send_sprite(100, 300, 500, 20, 1);
    drain();

    random_phase(100, 0);
    drain();
    write_all(0, 0, 0, 0);
    send_idle_pct = 65;
    random_phase(100, 1);
    drain();
    write_all(4095, 4095, 2047, 4095);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    random_phase(100, 0);
    drain();
    write_all($urandom_range(200, 1000), $urandom_range(4095), $urandom_range(300),
              $urandom_range(4095));
    send_idle_pct = 18;
    recv_stall_pct = 18;
    random_phase(100, 0);
    drain();

    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #300_000_000;
    $display("status: fail");
    $finish;
  end
endmodule

### filelist.f
rtl/core/scea_pkg.sv
rtl/core/scea_front.sv
rtl/core/scea_back.sv
rtl/core/sprite_cluster_edge_anchor.sv
bench/tb_sprite_cluster_edge_anchor.sv
